// ===== rtl/ggs_pkg.sv =====
package ggs_pkg;

  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 15;
  localparam int unsigned DUTY_W      = 15;
  localparam int unsigned RAMP_W      = 14;

  // register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_DEBOUNCE    = 3'd0,
    REG_Y_DEBOUNCE    = 3'd1,
    REG_GRAB_DEBOUNCE = 3'd2,
    REG_LOWER_TIME    = 3'd3,
    REG_GRIP_SECONDS  = 3'd4,
    REG_Y_RAMP_SPAN   = 3'd5,
    REG_Y_BASE_DUTY   = 3'd6,
    REG_Z_RUN_DUTY    = 3'd7
  } cfg_reg_t;

  // reset values of the registers
  localparam logic [7:0]        RST_X_DEBOUNCE    = 8'd100;
  localparam logic [7:0]        RST_Y_DEBOUNCE    = 8'd30;
  localparam logic [7:0]        RST_GRAB_DEBOUNCE = 8'd30;
  localparam logic [7:0]        RST_LOWER_TIME    = 8'd65;
  localparam logic [7:0]        RST_GRIP_SECONDS  = 8'd3;
  localparam logic [RAMP_W-1:0] RST_Y_RAMP_SPAN   = 14'd8192;
  localparam logic [RAMP_W-1:0] RST_Y_BASE_DUTY   = 14'h1fff;
  localparam logic [DUTY_W-1:0] RST_Z_RUN_DUTY    = 15'h1fff;

  localparam logic [RAMP_W-1:0] RAMP_MAX  = 14'h3fff;
  localparam logic [3:0]        DEC_BASE  = 4'd10;

  typedef enum logic [2:0] {
    SEQ_IDLE    = 3'd0,
    SEQ_LOWER   = 3'd1,
    SEQ_GRIP    = 3'd2,
    SEQ_RAISE   = 3'd3,
    SEQ_HOME    = 3'd4,
    SEQ_RELEASE = 3'd5
  } seq_t;

  typedef struct packed {
    logic [7:0]        x_debounce;
    logic [7:0]        y_debounce;
    logic [7:0]        grab_debounce;
    logic [7:0]        lower_time;
    logic [7:0]        grip_seconds;
    logic [RAMP_W-1:0] y_ramp_span;
    logic [RAMP_W-1:0] y_base_duty;
    logic [DUTY_W-1:0] z_run_duty;
  } cfg_t;

  typedef struct packed {
    logic ms_tick;
    logic jog_right;
    logic jog_left;
    logic jog_up;
    logic jog_down;
    logic grab_button;
    logic x_origin_switch;
    logic y_origin_switch;
    logic y_end_switch;
    logic z_top_switch;
  } inword_t;

  typedef struct packed {
    logic x_jog;
    logic y_jog;
    logic z_run;
    logic lower;
    logic grip;
    logic done;
    logic home_x;
    logic home_y;
    logic run;
    logic glevel;
  } flags_t;

  typedef struct packed {
    logic z_top;
    logic x_org;
    logic y_org;
    logic y_end;
  } latches_t;

  typedef struct packed {
    logic x_dir;
    logic y_dir;
    logic z_dir;
    logic x_en;
  } dirs_t;

  typedef struct packed {
    logic [7:0]        right_hold;
    logic [7:0]        left_hold;
    logic [7:0]        up_hold;
    logic [7:0]        down_hold;
    logic [7:0]        grab_hold;
    logic [3:0]        ms_units;
    logic [3:0]        tens_ms;
    logic [3:0]        hundreds_ms;
    logic [7:0]        lower_timer;
    logic [7:0]        grip_timer;
    logic              step_phase;
    logic [RAMP_W-1:0] y_ramp;
    seq_t              seq;
    flags_t            flags;
    latches_t          latches;
    dirs_t             dirs;
  } state_t;

  typedef struct packed {
    logic              x_step;
    logic              x_enable;
    logic              x_direction;
    logic              y_direction;
    logic [DUTY_W-1:0] y_duty;
    logic              z_direction;
    logic [DUTY_W-1:0] z_duty;
    logic              gripper_drive;
    logic [2:0]        sequence_step;
  } result_t;

endpackage

// ===== rtl/ggs_cfg.sv =====
module ggs_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [ggs_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [ggs_pkg::CFG_DATA_W-1:0] wr_data,
  output ggs_pkg::cfg_t                 cfg_o
);
  import ggs_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (cfg_reg_t'(wr_index))
        REG_X_DEBOUNCE:    cfg_nxt.x_debounce    = wr_data[7:0];
        REG_Y_DEBOUNCE:    cfg_nxt.y_debounce    = wr_data[7:0];
        REG_GRAB_DEBOUNCE: cfg_nxt.grab_debounce = wr_data[7:0];
        REG_LOWER_TIME:    cfg_nxt.lower_time    = wr_data[7:0];
        REG_GRIP_SECONDS:  cfg_nxt.grip_seconds  = wr_data[7:0];
        REG_Y_RAMP_SPAN:   cfg_nxt.y_ramp_span   = wr_data[RAMP_W-1:0];
        REG_Y_BASE_DUTY:   cfg_nxt.y_base_duty   = wr_data[RAMP_W-1:0];
        REG_Z_RUN_DUTY:    cfg_nxt.z_run_duty    = wr_data[DUTY_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_debounce    <= RST_X_DEBOUNCE;
      cfg_r.y_debounce    <= RST_Y_DEBOUNCE;
      cfg_r.grab_debounce <= RST_GRAB_DEBOUNCE;
      cfg_r.lower_time    <= RST_LOWER_TIME;
      cfg_r.grip_seconds  <= RST_GRIP_SECONDS;
      cfg_r.y_ramp_span   <= RST_Y_RAMP_SPAN;
      cfg_r.y_base_duty   <= RST_Y_BASE_DUTY;
      cfg_r.z_run_duty    <= RST_Z_RUN_DUTY;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

// ===== rtl/ggs_pass.sv =====
module ggs_pass (
  input  ggs_pkg::cfg_t    cfg_i,
  input  ggs_pkg::state_t  st_i,
  input  ggs_pkg::inword_t in_i,
  output ggs_pkg::state_t  st_o,
  output ggs_pkg::result_t res_o
);
  import ggs_pkg::*;

  state_t            s;
  logic [DUTY_W-1:0] y_duty_c;
  logic [DUTY_W-1:0] z_duty_c;

  // next state of one control pass
  always_comb begin
    s        = st_i;
    y_duty_c = '0;
    z_duty_c = '0;

    // x jog debounce
    if (in_i.jog_right) begin
      s.left_hold = '0;
      if (s.right_hold >= cfg_i.x_debounce) begin
        s.dirs.x_en   = 1'b1;
        s.dirs.x_dir  = 1'b0;
        s.flags.x_jog = 1'b1;
      end else begin
        s.right_hold = s.right_hold + 8'd1;
      end
    end else if (in_i.jog_left) begin
      s.right_hold = '0;
      if (!s.latches.x_org) begin
        if (s.left_hold >= cfg_i.x_debounce) begin
          s.dirs.x_en   = 1'b1;
          s.dirs.x_dir  = 1'b1;
          s.flags.x_jog = 1'b1;
        end else begin
          s.left_hold = s.left_hold + 8'd1;
        end
      end else begin
        s.dirs.x_en = 1'b0;
      end
    end else begin
      s.right_hold  = '0;
      s.left_hold   = '0;
      s.flags.x_jog = 1'b0;
    end

    // y jog debounce
    if (in_i.jog_up) begin
      s.down_hold = '0;
      if (!s.latches.y_end) begin
        if (s.up_hold >= cfg_i.y_debounce) begin
          s.dirs.y_dir  = 1'b1;
          s.flags.y_jog = 1'b1;
        end else begin
          s.up_hold = s.up_hold + 8'd1;
        end
      end else begin
        s.y_ramp      = '0;
        s.flags.y_jog = 1'b0;
      end
    end else if (in_i.jog_down) begin
      s.up_hold = '0;
      if (!s.latches.y_org) begin
        if (s.down_hold >= cfg_i.y_debounce) begin
          s.dirs.y_dir  = 1'b0;
          s.flags.y_jog = 1'b1;
        end else begin
          s.down_hold = s.down_hold + 8'd1;
        end
      end else begin
        s.y_ramp      = '0;
        s.flags.y_jog = 1'b0;
      end
    end else begin
      s.up_hold     = '0;
      s.down_hold   = '0;
      s.flags.y_jog = 1'b0;
    end

    // y ramp
    if (s.flags.y_jog || s.flags.home_y) begin
      if (s.y_ramp <= cfg_i.y_ramp_span && s.y_ramp != RAMP_MAX) begin
        s.y_ramp = s.y_ramp + 14'd1;
      end
      y_duty_c = {1'b0, cfg_i.y_base_duty} + {1'b0, s.y_ramp};
    end else begin
      if (s.y_ramp != '0) begin
        s.y_ramp = s.y_ramp - 14'd1;
      end
      y_duty_c = {1'b0, s.y_ramp};
    end

    // grab sequence
    unique case (s.seq)
      SEQ_IDLE: begin
        s.flags.run = 1'b0;
        if (in_i.grab_button) begin
          if (s.grab_hold >= cfg_i.grab_debounce) begin
            s.seq = SEQ_LOWER;
          end else begin
            s.grab_hold = s.grab_hold + 8'd1;
          end
        end else begin
          s.grab_hold = '0;
        end
        s.latches.z_top = 1'b0;
      end
      SEQ_LOWER: begin
        s.dirs.z_dir = 1'b1;
        if (!s.flags.run) begin
          s.flags.run   = 1'b1;
          s.flags.z_run = 1'b1;
          s.flags.lower = 1'b1;
        end else if (!s.flags.lower) begin
          s.flags.run   = 1'b0;
          s.flags.z_run = 1'b0;
          s.seq         = SEQ_GRIP;
        end
      end
      SEQ_GRIP: begin
        s.flags.grip = 1'b1;
        if (s.flags.done) begin
          s.seq = SEQ_RAISE;
        end
      end
      SEQ_RAISE: begin
        s.dirs.z_dir = 1'b0;
        if (!s.flags.run) begin
          s.flags.run   = 1'b1;
          s.flags.z_run = 1'b1;
        end else if (s.latches.z_top) begin
          s.flags.run   = 1'b0;
          s.flags.z_run = 1'b0;
          s.seq         = SEQ_HOME;
        end
      end
      SEQ_HOME: begin
        if (!s.flags.run) begin
          s.flags.run    = 1'b1;
          s.flags.home_x = 1'b1;
          s.flags.home_y = 1'b1;
          s.dirs.x_en    = 1'b1;
          s.dirs.x_dir   = 1'b1;
          s.dirs.y_dir   = 1'b0;
        end else begin
          if (s.latches.x_org) begin
            s.flags.home_x = 1'b0;
            s.dirs.x_en    = 1'b0;
          end
          if (s.latches.y_org) begin
            s.flags.home_y = 1'b0;
            s.y_ramp       = '0;
            y_duty_c       = '0;
          end
          if (!s.flags.home_x && !s.flags.home_y) begin
            s.flags.run = 1'b0;
            s.seq       = SEQ_RELEASE;
          end
        end
      end
      SEQ_RELEASE: begin
        s.flags.grip = 1'b0;
        s.seq        = SEQ_IDLE;
      end
      default: begin
      end
    endcase

    z_duty_c = s.flags.z_run ? cfg_i.z_run_duty : '0;

    // 1 ms tick work
    if (in_i.ms_tick) begin
      s.latches.z_top = in_i.z_top_switch;
      s.latches.x_org = in_i.x_origin_switch;
      s.latches.y_org = in_i.y_origin_switch;
      s.latches.y_end = in_i.y_end_switch;

      s.ms_units = s.ms_units + 4'd1;
      if (s.ms_units >= DEC_BASE) begin
        s.ms_units = '0;
        s.tens_ms  = s.tens_ms + 4'd1;
      end
      if (s.tens_ms >= DEC_BASE) begin
        s.tens_ms     = '0;
        s.hundreds_ms = s.hundreds_ms + 4'd1;
        if (s.flags.lower) begin
          s.lower_timer = s.lower_timer + 8'd1;
          if (s.lower_timer >= cfg_i.lower_time) begin
            s.lower_timer = '0;
            s.flags.lower = 1'b0;
          end
        end
      end
      if (s.hundreds_ms >= DEC_BASE) begin
        s.hundreds_ms = '0;
        if (s.flags.grip) begin
          s.grip_timer = s.grip_timer + 8'd1;
        end
      end

      if (s.flags.x_jog || s.flags.home_x) begin
        s.step_phase = ~s.step_phase;
      end else begin
        s.step_phase = 1'b0;
        s.dirs.x_en  = 1'b0;
      end

      if (s.flags.grip) begin
        // coil on for the first three ms of every five
        s.flags.glevel = (s.ms_units < 4'd3) ||
                         (s.ms_units >= 4'd5 && s.ms_units < 4'd8);
        if (s.grip_timer >= cfg_i.grip_seconds) begin
          s.grip_timer = '0;
          s.flags.done = 1'b1;
        end
      end else begin
        s.flags.glevel = 1'b0;
        s.flags.done   = 1'b0;
        s.grip_timer   = '0;
      end
    end
  end

  // result word from the state at the end of the pass
  always_comb begin
    res_o.x_step        = s.step_phase;
    res_o.x_enable      = s.dirs.x_en;
    res_o.x_direction   = s.dirs.x_dir;
    res_o.y_direction   = s.dirs.y_dir;
    res_o.y_duty        = y_duty_c;
    res_o.z_direction   = s.dirs.z_dir;
    res_o.z_duty        = z_duty_c;
    res_o.gripper_drive = s.flags.glevel;
    res_o.sequence_step = s.seq;
  end

  assign st_o = s;

endmodule

// ===== rtl/gantry_grab_sequencer.sv =====
// channel | direction | handshake           | word
// in_     | input     | in_valid / in_stall | ten switch and tick bits
// out_    | output    | out_valid/out_stall | drive levels, duties, step
// cfg_    | input     | cfg_wr_en           | index and write data
//
// one word per cycle sustained while out_stall is low; an accepted word goes
// through the input register, then the pass logic, into the result register
// the pass logic and the state register close a loop, so back to back
// words see each other's state
// rst_n is synchronous: state idle, config at its reset values
// in_stall rises only when the input and result registers are both full and
// out_stall is high
module gantry_grab_sequencer (
  input  logic                            clk,
  input  logic                            rst_n,

  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_ms_tick,
  input  logic                            in_jog_right,
  input  logic                            in_jog_left,
  input  logic                            in_jog_up,
  input  logic                            in_jog_down,
  input  logic                            in_grab_button,
  input  logic                            in_x_origin_switch,
  input  logic                            in_y_origin_switch,
  input  logic                            in_y_end_switch,
  input  logic                            in_z_top_switch,

  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_x_step,
  output logic                            out_x_enable,
  output logic                            out_x_direction,
  output logic                            out_y_direction,
  output logic [ggs_pkg::DUTY_W-1:0]      out_y_duty,
  output logic                            out_z_direction,
  output logic [ggs_pkg::DUTY_W-1:0]      out_z_duty,
  output logic                            out_gripper_drive,
  output logic [2:0]                      out_sequence_step,

  input  logic                            cfg_wr_en,
  input  logic [ggs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ggs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import ggs_pkg::*;

  cfg_t    cfg;
  inword_t in_r;
  logic    in_vld_r;
  result_t res_r;
  logic    res_vld_r;
  state_t  st_r;
  state_t  st_nxt;
  result_t res_nxt;
  logic    in_take;
  logic    move;

  ggs_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_wr_en),
    .wr_index (cfg_index),
    .wr_data  (cfg_wdata),
    .cfg_o    (cfg)
  );

  ggs_pass u_pass (
    .cfg_i (cfg),
    .st_i  (st_r),
    .in_i  (in_r),
    .st_o  (st_nxt),
    .res_o (res_nxt)
  );

  // the buffered word moves into the result register when that slot frees
  assign move     = in_vld_r && (!res_vld_r || !out_stall);
  assign in_stall = in_vld_r && res_vld_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  // control: valid flags and controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      res_vld_r <= 1'b0;
      st_r      <= '{seq: SEQ_IDLE, default: '0};
    end else begin
      if (in_take) begin
        in_vld_r <= 1'b1;
      end else if (move) begin
        in_vld_r <= 1'b0;
      end
      if (move) begin
        res_vld_r <= 1'b1;
        st_r      <= st_nxt;
      end else if (!out_stall) begin
        res_vld_r <= 1'b0;
      end
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r <= '{ms_tick:         in_ms_tick,
                jog_right:       in_jog_right,
                jog_left:        in_jog_left,
                jog_up:          in_jog_up,
                jog_down:        in_jog_down,
                grab_button:     in_grab_button,
                x_origin_switch: in_x_origin_switch,
                y_origin_switch: in_y_origin_switch,
                y_end_switch:    in_y_end_switch,
                z_top_switch:    in_z_top_switch};
    end
    if (move) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = res_vld_r;
  assign out_x_step        = res_r.x_step;
  assign out_x_enable      = res_r.x_enable;
  assign out_x_direction   = res_r.x_direction;
  assign out_y_direction   = res_r.y_direction;
  assign out_y_duty        = res_r.y_duty;
  assign out_z_direction   = res_r.z_direction;
  assign out_z_duty        = res_r.z_duty;
  assign out_gripper_drive = res_r.gripper_drive;
  assign out_sequence_step = res_r.sequence_step;

  // the state only advances when a word goes through the pass logic
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !move |=> $stable(st_r))
    else $error("controller state changed without a word");

  // a result waiting on a stalled sink is not dropped
  a_res_kept: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld_r && out_stall |=> res_vld_r)
    else $error("stalled result word lost");

  // input side only backs up when both registers are occupied
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_vld_r && res_vld_r))
    else $error("input stalled with a free slot");

  // z only driven while lowering or raising
  a_z_run: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld_r && (res_r.z_duty != '0) |->
      (res_r.sequence_step == SEQ_LOWER || res_r.sequence_step == SEQ_RAISE))
    else $error("z drive outside lower or raise");

endmodule
